FILE: rtl/aabb_frustum_cull_top_defines.svh
// assertion macros shared by the frustum cull checker
// no dependencies; included by afc_checker.sv
`ifndef AABB_FRUSTUM_CULL_TOP_DEFINES_SVH
`define AABB_FRUSTUM_CULL_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define AFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/afc_pkg.sv
// shared constants and codes for the frustum cull block
// no dependencies; used by the top level and the checker
package afc_pkg;

    localparam int DATA_W         = 32;
    localparam int IDX_W          = 3;
    localparam int NUM_PLANES_DEF = 6;
    localparam int COEF_PER_PLANE = 4;
    localparam int ROW_W          = COEF_PER_PLANE * DATA_W;
    localparam int PROD_W         = 2 * DATA_W;
    // three full products plus the scaled offset fit in two guard bits
    localparam int ACC_W          = PROD_W + 2;
    localparam int FRAC_W         = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

endpackage

FILE: rtl/aabb_frustum_cull_top.sv
// frustum cull top level: plane store, one shared 32x32 multiplier and its sequencer
// depends on afc_pkg and afc_ram
//
// Tests axis-aligned boxes against NUM_PLANES stored inward-facing planes with the
// p-vertex test. A word with opcode load writes plane_a..plane_d into row plane_index
// of the plane store in the cycle it is accepted and gives no result; an index of
// NUM_PLANES or more is dropped. A word with opcode test gives one result: visible
// set and failing_plane equal to NUM_PLANES (low three bits) when no plane puts the
// box outside, else visible clear and the index of the first plane whose distance is
// negative. Planes must be loaded before a test reads them. Each plane visit runs the
// steps store read, three passes through the one signed 32x32 multiplier, final add
// and sign check, in that order. The input is not ready while a test is in work. The
// result sits in an output register, so the next word is taken while a result still
// waits on out_ready; a test that finishes while the previous result is still held
// waits in its check step until the slot frees.
module aabb_frustum_cull_top #(
    parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [afc_pkg::IDX_W-1:0]        plane_index,
    input  logic signed [afc_pkg::DATA_W-1:0] plane_a,
    input  logic signed [afc_pkg::DATA_W-1:0] plane_b,
    input  logic signed [afc_pkg::DATA_W-1:0] plane_c,
    input  logic signed [afc_pkg::DATA_W-1:0] plane_d,
    input  logic signed [afc_pkg::DATA_W-1:0] min_x,
    input  logic signed [afc_pkg::DATA_W-1:0] min_y,
    input  logic signed [afc_pkg::DATA_W-1:0] min_z,
    input  logic signed [afc_pkg::DATA_W-1:0] max_x,
    input  logic signed [afc_pkg::DATA_W-1:0] max_y,
    input  logic signed [afc_pkg::DATA_W-1:0] max_z,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             visible,
    output logic [afc_pkg::IDX_W-1:0]        failing_plane
);
    import afc_pkg::*;

    localparam int AW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam logic [AW-1:0]    LAST_PLANE = AW'(NUM_PLANES - 1);
    localparam logic [IDX_W-1:0] VIS_CODE   = IDX_W'(NUM_PLANES);

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_MUL   = 5'b00100,
        S_SUM   = 5'b01000,
        S_CHECK = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    state_t                    state_reg, state_next;
    axis_t                     axis_reg, axis_next;
    logic [AW-1:0]             plane_reg, plane_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      visible_reg, visible_next;
    logic [IDX_W-1:0]          fail_reg, fail_next;

    // payload registers, no reset
    logic signed [DATA_W-1:0]  min_x_reg, min_y_reg, min_z_reg;
    logic signed [DATA_W-1:0]  max_x_reg, max_y_reg, max_z_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic                      in_fire;
    logic                      load_fire;
    logic                      test_fire;
    logic                      ram_we;
    logic                      ram_re;
    logic [AW-1:0]             ram_addr;
    logic [ROW_W-1:0]          ram_wdata;
    logic [ROW_W-1:0]          ram_rdata;

    logic signed [DATA_W-1:0]  coef;
    logic signed [DATA_W-1:0]  pt;
    logic signed [PROD_W-1:0]  mul_res;
    logic signed [DATA_W-1:0]  row_d;
    logic signed [ACC_W-1:0]   d_ext;
    logic signed [ACC_W-1:0]   prod_ext;
    logic                      acc_neg;
    logic                      slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (opcode == OP_LOAD);
    assign test_fire = in_fire && (opcode == OP_TEST);

    // plane store: one row {a, b, c, d} per plane
    assign ram_we    = load_fire && (int'(plane_index) < NUM_PLANES);
    assign ram_re    = (state_reg == S_READ);
    assign ram_addr  = ram_we ? AW'(plane_index) : plane_reg;
    assign ram_wdata = {plane_a, plane_b, plane_c, plane_d};

    afc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_PLANES)
    ) u_plane_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // coefficient of the current axis and the p-vertex coordinate for it:
    // max corner where the coefficient is zero or more, min corner otherwise
    always_comb
    begin
        unique case (axis_reg)
            AX_X:
            begin
                coef = ram_rdata[4*DATA_W-1:3*DATA_W];
                pt   = coef[DATA_W-1] ? min_x_reg : max_x_reg;
            end
            AX_Y:
            begin
                coef = ram_rdata[3*DATA_W-1:2*DATA_W];
                pt   = coef[DATA_W-1] ? min_y_reg : max_y_reg;
            end
            AX_Z:
            begin
                coef = ram_rdata[2*DATA_W-1:DATA_W];
                pt   = coef[DATA_W-1] ? min_z_reg : max_z_reg;
            end
            default:
            begin
                coef = '0;
                pt   = '0;
            end
        endcase
    end

    // the one shared multiplier, registered before the accumulate
    assign mul_res  = coef * pt;
    assign row_d    = ram_rdata[DATA_W-1:0];
    // offset moved from Q16.16 to Q32.32
    assign d_ext    = {{(ACC_W-DATA_W-FRAC_W){row_d[DATA_W-1]}}, row_d, {FRAC_W{1'b0}}};
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_neg  = acc_reg[ACC_W-1];
    // result slot is free when empty or emptied this cycle
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        plane_next     = plane_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        visible_next   = visible_reg;
        fail_next      = fail_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (test_fire)
                begin
                    plane_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                axis_next  = AX_X;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = mul_res;
                // first pass seeds the sum with the offset term
                if (axis_reg == AX_X)
                begin
                    acc_next = d_ext;
                end
                else
                begin
                    acc_next = acc_reg + prod_ext;
                end
                if (axis_reg == AX_Z)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    axis_next = axis_t'(axis_reg + 2'd1);
                end
            end
            S_SUM:
            begin
                acc_next   = acc_reg + prod_ext;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (acc_neg || (plane_reg == LAST_PLANE))
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        visible_next   = !acc_neg;
                        fail_next      = acc_neg ? IDX_W'(plane_reg) : VIS_CODE;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= AX_X;
            plane_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            plane_reg     <= plane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        visible_reg <= visible_next;
        fail_reg    <= fail_next;
        if (test_fire)
        begin
            min_x_reg <= min_x;
            min_y_reg <= min_y;
            min_z_reg <= min_z;
            max_x_reg <= max_x;
            max_y_reg <= max_y;
            max_z_reg <= max_z;
        end
    end

    assign out_valid     = out_valid_reg;
    assign visible       = visible_reg;
    assign failing_plane = fail_reg;

endmodule

FILE: rtl/afc_ram.sv
// generic single-port ram with registered read
// no dependencies; holds the plane rows of the frustum cull block
module afc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 6
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                     wdata,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/afc_checker.sv
// port-level checks for the frustum cull block, bound to its top level
// depends on afc_pkg and aabb_frustum_cull_top_defines.svh
`include "aabb_frustum_cull_top_defines.svh"

module afc_checker #(
    parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      opcode,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      visible,
    input logic [afc_pkg::IDX_W-1:0] failing_plane
);
    import afc_pkg::*;

    localparam logic [IDX_W-1:0] VIS_CODE = IDX_W'(NUM_PLANES);

    // a held result word keeps its fields
    `AFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(visible) && $stable(failing_plane), "result word changed while stalled")

    // a visible box reports the no-failure code
    `AFC_ASSERT_NOW(a_vis_code, out_valid && visible, failing_plane == VIS_CODE, "visible result with a plane index")

    // a test keeps the input busy while planes are visited
    `AFC_ASSERT_NEXT(a_test_busy, in_valid && in_ready && (opcode == OP_TEST), !in_ready, "input ready right after a test word")

    // with no result held, no result appears the cycle after an accepted word
    `AFC_ASSERT_NEXT(a_no_early, in_valid && in_ready && !out_valid, !out_valid, "result appeared too early")

endmodule

bind aabb_frustum_cull_top afc_checker #(.NUM_PLANES(NUM_PLANES)) u_afc_checker (.*);

FILE: verif/tb_aabb_frustum_cull_top.sv
// testbench for aabb_frustum_cull_top: p-vertex box culling against six stored planes
// depends on afc_pkg and the rtl top level; self-checking, no files or arguments
`timescale 1ns / 100ps

module tb_aabb_frustum_cull_top;

    import afc_pkg::*;

    localparam int NUM_PLANES = NUM_PLANES_DEF;
    // three 64-bit products plus the scaled offset, with a spare sign bit
    localparam int DIST_W     = 2 * DATA_W + 3;
    localparam int ONE        = 65536;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam int TAIL_CYCLES = 48;

    // coefficient slots of one stored plane
    localparam int COEF_A = 0;
    localparam int COEF_B = 1;
    localparam int COEF_C = 2;
    localparam int COEF_D = 3;

    typedef enum int {
        NEAR_PLANE, FAR_PLANE, LEFT_PLANE, RIGHT_PLANE, TOP_PLANE, BOTTOM_PLANE
    } plane_e;

    // handshake pressure for a stretch of words
    typedef enum int { QUIET, SEND_GAPS, RECV_STALLS, BOTH_GAPS } idle_mode_e;

    typedef struct {
        logic                     opcode;
        logic [IDX_W-1:0]         plane_index;
        logic signed [DATA_W-1:0] plane_a, plane_b, plane_c, plane_d;
        logic signed [DATA_W-1:0] min_x, min_y, min_z;
        logic signed [DATA_W-1:0] max_x, max_y, max_z;
        bit                       drain_first;
        int                       idle_pct;
        int                       stall_pct;
    } cull_word_t;

    typedef struct {
        logic             visible;
        logic [IDX_W-1:0] failing_plane;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     opcode;
    logic [IDX_W-1:0]         plane_index;
    logic signed [DATA_W-1:0] plane_a, plane_b, plane_c, plane_d;
    logic signed [DATA_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     visible;
    logic [IDX_W-1:0]         failing_plane;

    // words waiting for the driver, and the one on the bus
    cull_word_t word_q[$];
    cull_word_t cur_word = '{default: 0};
    cull_word_t next_word;
    logic       in_taken = 1'b0;
    int         recv_stall_pct = 0;

    // predictor state: plane store copy and the verdicts still owed by the block
    logic signed [DATA_W-1:0] plane_mem [NUM_PLANES][4];
    verdict_t verdict_q[$];
    verdict_t want;

    int  fail_count = 0;
    int  real_words = 0;
    bit  drain_next = 1'b0;
    int  frust_lo [3];
    int  frust_hi [3];

    aabb_frustum_cull_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .plane_index   (plane_index),
        .plane_a       (plane_a),
        .plane_b       (plane_b),
        .plane_c       (plane_c),
        .plane_d       (plane_d),
        .min_x         (min_x),
        .min_y         (min_y),
        .min_z         (min_z),
        .max_x         (max_x),
        .max_y         (max_y),
        .max_z         (max_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .visible       (visible),
        .failing_plane (failing_plane)
    );

    // payload ports follow the word on the bus
    assign opcode      = cur_word.opcode;
    assign plane_index = cur_word.plane_index;
    assign plane_a     = cur_word.plane_a;
    assign plane_b     = cur_word.plane_b;
    assign plane_c     = cur_word.plane_c;
    assign plane_d     = cur_word.plane_d;
    assign min_x       = cur_word.min_x;
    assign min_y       = cur_word.min_y;
    assign min_z       = cur_word.min_z;
    assign max_x       = cur_word.max_x;
    assign max_y       = cur_word.max_y;
    assign max_z       = cur_word.max_z;

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // p-vertex test: per axis take max where the coefficient is >= 0, min otherwise,
    // sum exactly in q32.32 and stop at the first plane that comes out negative
    function automatic verdict_t cull_box(cull_word_t w);
        verdict_t                 v;
        logic signed [DATA_W-1:0] lo_c [3];
        logic signed [DATA_W-1:0] hi_c [3];
        logic signed [DATA_W-1:0] coef;
        logic signed [DIST_W-1:0] dist_acc;
        lo_c[0] = w.min_x;
        lo_c[1] = w.min_y;
        lo_c[2] = w.min_z;
        hi_c[0] = w.max_x;
        hi_c[1] = w.max_y;
        hi_c[2] = w.max_z;
        v.visible       = 1'b1;
        v.failing_plane = IDX_W'(NUM_PLANES);
        for (int p = 0; p < NUM_PLANES && v.visible; p++) begin
            // offset term moves from q16.16 up to q32.32
            dist_acc = longint'(plane_mem[p][COEF_D]) * 65536;
            for (int k = COEF_A; k <= COEF_C; k++) begin
                coef = plane_mem[p][k];
                dist_acc = dist_acc
                           + longint'(coef) * longint'((coef >= 0) ? hi_c[k] : lo_c[k]);
            end
            // exactly zero counts as inside
            if (dist_acc < 0) begin
                v.visible       = 1'b0;
                v.failing_plane = IDX_W'(p);
            end
        end
        return v;
    endfunction

    // a load past the last plane is dropped by the block
    function automatic void store_plane(cull_word_t w);
        if (w.plane_index < NUM_PLANES) begin
            plane_mem[w.plane_index][COEF_A] = w.plane_a;
            plane_mem[w.plane_index][COEF_B] = w.plane_b;
            plane_mem[w.plane_index][COEF_C] = w.plane_c;
            plane_mem[w.plane_index][COEF_D] = w.plane_d;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int srand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // stamps the idling of the current stretch; stretches rotate every 70 words, dropped loads not counted
    function automatic void push_word(cull_word_t w);
        idle_mode_e mode;
        mode = idle_mode_e'((real_words / 70) % 4);
        w.drain_first = drain_next;
        drain_next    = 1'b0;
        case (mode)
            QUIET:       begin w.idle_pct = 0;  w.stall_pct = 0;  end
            SEND_GAPS:   begin w.idle_pct = 76; w.stall_pct = 0;  end
            RECV_STALLS: begin w.idle_pct = 0;  w.stall_pct = 76; end
            default:     begin w.idle_pct = 28; w.stall_pct = 28; end
        endcase
        if (w.opcode == OP_TEST || w.plane_index < NUM_PLANES)
            real_words++;
        word_q.push_back(w);
    endfunction

    function automatic cull_word_t plane_word(int idx, logic signed [DATA_W-1:0] a,
                                              logic signed [DATA_W-1:0] b,
                                              logic signed [DATA_W-1:0] c,
                                              logic signed [DATA_W-1:0] d);
        cull_word_t w;
        w = '{default: 0};
        w.opcode      = OP_LOAD;
        w.plane_index = IDX_W'(idx);
        w.plane_a     = a;
        w.plane_b     = b;
        w.plane_c     = c;
        w.plane_d     = d;
        // box fields are don't-care on a load, toggle min_x and max_z anyway
        w.min_x       = $urandom;
        w.max_z       = $urandom;
        return w;
    endfunction

    function automatic cull_word_t box_word(logic signed [DATA_W-1:0] x0,
                                            logic signed [DATA_W-1:0] y0,
                                            logic signed [DATA_W-1:0] z0,
                                            logic signed [DATA_W-1:0] x1,
                                            logic signed [DATA_W-1:0] y1,
                                            logic signed [DATA_W-1:0] z1);
        cull_word_t w;
        w = '{default: 0};
        w.opcode      = OP_TEST;
        w.plane_index = IDX_W'($urandom);
        w.plane_a     = $urandom;
        w.min_x       = x0;
        w.min_y       = y0;
        w.min_z       = z0;
        w.max_x       = x1;
        w.max_y       = y1;
        w.max_z       = z1;
        return w;
    endfunction

    // roughly axis-aligned inward plane with small tilt on the other two axes
    function automatic cull_word_t frustum_plane(plane_e p);
        int cf [3];
        int axis;
        bit lower;
        int d;
        case (p)
            NEAR_PLANE:   begin axis = 2; lower = 1'b1; end
            FAR_PLANE:    begin axis = 2; lower = 1'b0; end
            LEFT_PLANE:   begin axis = 0; lower = 1'b1; end
            RIGHT_PLANE:  begin axis = 0; lower = 1'b0; end
            TOP_PLANE:    begin axis = 1; lower = 1'b0; end
            default:      begin axis = 1; lower = 1'b1; end
        endcase
        for (int k = 0; k < 3; k++)
            cf[k] = ($urandom_range(3) == 0) ? 0 : srand_between(-2048, 2048);
        if (lower) begin
            cf[axis] = ONE + int'($urandom_range(255));
            d        = -frust_lo[axis];
        end else begin
            cf[axis] = -ONE - int'($urandom_range(255));
            d        = frust_hi[axis];
        end
        return plane_word(int'(p), cf[0], cf[1], cf[2], d);
    endfunction

    // box around the current frustum, or anywhere in the full range when wide
    function automatic cull_word_t random_box(bit wide);
        int lo [3];
        int hi [3];
        int mid;
        int half;
        int tmp;
        if (wide)
            return box_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int k = 0; k < 3; k++) begin
            mid   = srand_between(frust_lo[k] - (1 << 19), frust_hi[k] + (1 << 19));
            half  = int'($urandom_range(1 << 18));
            lo[k] = mid - half;
            hi[k] = mid + half;
            // corners handed over inverted now and then
            if ($urandom_range(9) == 0) begin
                tmp   = lo[k];
                lo[k] = hi[k];
                hi[k] = tmp;
            end
        end
        return box_word(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // ------------------------------------------------------------------
    // driver: new word at the falling edge once the last one was taken
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!in_valid || in_taken) begin
                // a drain word is held back until the block owes nothing
                if (word_q.size() != 0
                    && !(word_q[0].drain_first && verdict_q.size() != 0)
                    && $urandom_range(99) >= word_q[0].idle_pct) begin
                    next_word      = word_q.pop_front();
                    recv_stall_pct = next_word.stall_pct;
                    cur_word       <= next_word;
                    in_valid       <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: accepted words feed the predictor, results are checked in order
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                if (cur_word.opcode == OP_LOAD)
                    store_plane(cur_word);
                else
                    verdict_q.push_back(cull_box(cur_word));
            end
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result with no test word outstanding: visible=%0b plane=%0d",
                           visible, failing_plane);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (visible !== want.visible) begin
                        $error("visible: expected %0b, got %0b", want.visible, visible);
                        fail_count++;
                    end
                    if (failing_plane !== want.failing_plane) begin
                        $error("failing_plane: expected %0d, got %0d",
                               want.failing_plane, failing_plane);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int n_boxes;
        bit partial;

        // every plane gets written before the first test reads the store
        push_word(plane_word(NEAR_PLANE,   0, 0, ONE, 0));
        push_word(plane_word(FAR_PLANE,    0, 0, -ONE, 10 * ONE));
        push_word(plane_word(LEFT_PLANE,   ONE, 0, 0, 5 * ONE));
        push_word(plane_word(RIGHT_PLANE,  -ONE, 0, 0, 5 * ONE));
        push_word(plane_word(TOP_PLANE,    0, -ONE, 0, 5 * ONE));
        push_word(plane_word(BOTTOM_PLANE, 0, ONE, 0, 5 * ONE));

        // inside, then touching the near plane with a distance of exactly zero
        push_word(box_word(-ONE, -ONE, ONE, ONE, ONE, 2 * ONE));
        push_word(box_word(-ONE, -ONE, -3 * ONE, ONE, ONE, 0));
        // outside each plane in turn
        push_word(box_word(-ONE, -ONE, -3 * ONE, ONE, ONE, -ONE));
        push_word(box_word(-ONE, -ONE, 11 * ONE, ONE, ONE, 12 * ONE));
        push_word(box_word(-7 * ONE, -ONE, ONE, -6 * ONE, ONE, 2 * ONE));
        push_word(box_word(6 * ONE, -ONE, ONE, 7 * ONE, ONE, 2 * ONE));
        push_word(box_word(-ONE, 6 * ONE, ONE, ONE, 7 * ONE, 2 * ONE));
        push_word(box_word(-ONE, -7 * ONE, ONE, ONE, -6 * ONE, 2 * ONE));
        // min above max, used as given
        push_word(box_word(ONE, ONE, 5 * ONE, -ONE, -ONE, 4 * ONE));
        // full-range corners, straight and inverted
        push_word(box_word(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        push_word(box_word(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));

        // loads past the last plane must leave the store alone
        push_word(plane_word(NUM_PLANES, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        push_word(plane_word(2 ** IDX_W - 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        push_word(box_word(-ONE, -ONE, ONE, ONE, ONE, 2 * ONE));

        // extreme coefficients: sums beyond the signed 64-bit range either way
        push_word(plane_word(NEAR_PLANE, Q_MIN, Q_MAX, Q_MIN, Q_MIN));
        push_word(box_word(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        push_word(box_word(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        push_word(plane_word(FAR_PLANE, 0, 0, 0, Q_MAX));
        push_word(box_word(-ONE, -ONE, 11 * ONE, ONE, ONE, 12 * ONE));

        // random part: mostly full frusta followed by boxes around them, the rest
        // partial reloads and full-range noise; first group waits for a drained block
        drain_next = 1'b1;
        while (real_words < 1072) begin
            if (real_words > 40 && $urandom_range(11) == 0)
                drain_next = 1'b1;
            if ($urandom_range(99) < 80) begin
                for (int k = 0; k < 3; k++) begin
                    frust_lo[k] = -srand_between(1 << 16, 1 << 20);
                    frust_hi[k] = srand_between(1 << 16, 1 << 20);
                end
                partial = ($urandom_range(4) == 0);
                for (int p = 0; p < NUM_PLANES; p++)
                    if (!partial || $urandom_range(1))
                        push_word(frustum_plane(plane_e'(p)));
                n_boxes = $urandom_range(10, 3);
                repeat (n_boxes)
                    push_word(random_box($urandom_range(9) == 0));
            end else begin
                repeat ($urandom_range(3, 1))
                    push_word(plane_word($urandom_range(NUM_PLANES - 1),
                                         $urandom, $urandom, $urandom, $urandom));
                if ($urandom_range(9) < 3)
                    push_word(plane_word($urandom_range(2 ** IDX_W - 1, NUM_PLANES),
                                         $urandom, $urandom, $urandom, $urandom));
                n_boxes = $urandom_range(6, 2);
                repeat (n_boxes)
                    push_word(random_box(1'b1));
            end
        end

        // single reset at the start
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all words taken and all verdicts back, then room for a stray result
        while (word_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hang guard, many times the slowest legal run
    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
